// ===== sv/pixel_replication_upscaler_defines.svh =====
// Assertion macros for the pixel replication upscaler RTL.
// Included by the modules that check their own logic; no other dependencies.
`ifndef PIXEL_REPLICATION_UPSCALER_DEFINES_SVH
`define PIXEL_REPLICATION_UPSCALER_DEFINES_SVH

`ifndef SYNTHESIS

// cons must hold in the same cycle as ante
`define PRU_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// cons must hold in the cycle after ante
`define PRU_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define PRU_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define PRU_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

// ===== sv/pru_pkg.sv =====
// Shared types and constants of the pixel replication upscaler.
// No dependencies; imported by every module of the block.
package pru_pkg;

    localparam int ADDR_W     = 30;
    localparam int SRC_DIM_W  = 13;
    localparam int FACTOR_W   = 4;
    localparam int GAP_W      = 3;
    localparam int OFS_W      = 3;
    localparam int ROW_W      = 12;
    localparam int SRC_LINES_MAX = 4096;
    localparam int QUEUE_DEPTH   = 4;

    localparam int PIXEL_BITS_DEF      = 8;
    localparam int MAX_LINE_PIXELS_DEF = 4096;
    localparam int MAX_FACTOR_DEF      = 8;

    localparam int APB_DATA_W = 32;
    localparam int PADDR_W    = 5;
    localparam int REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_X_FACTOR   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_Y_FACTOR   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_X_GAP      = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_Y_GAP      = 3'd5;

    localparam logic [SRC_DIM_W-1:0] SRC_WIDTH_RST  = 13'd320;
    localparam logic [SRC_DIM_W-1:0] SRC_HEIGHT_RST = 13'd200;
    localparam logic [FACTOR_W-1:0]  X_FACTOR_RST   = 4'd2;
    localparam logic [FACTOR_W-1:0]  Y_FACTOR_RST   = 4'd2;
    localparam logic [GAP_W-1:0]     X_GAP_RST      = 3'd0;
    localparam logic [GAP_W-1:0]     Y_GAP_RST      = 3'd0;

    typedef struct packed {
        logic [SRC_DIM_W-1:0] src_width;
        logic [SRC_DIM_W-1:0] src_height;
        logic [FACTOR_W-1:0]  x_factor;
        logic [FACTOR_W-1:0]  y_factor;
        logic [GAP_W-1:0]     x_gap;
        logic [GAP_W-1:0]     y_gap;
    } cfg_t;

    // per-pixel control handed from front end to back end
    typedef struct packed {
        logic                err;
        logic                fend;
        logic [FACTOR_W-1:0] kx;
        logic [FACTOR_W-1:0] ly;
    } cmd_ctl_t;

endpackage

// ===== sv/pru_cfg_regs.sv =====
// APB register file holding the upscaler configuration.
// Depends on pru_pkg for register indexes, reset values and cfg_t.
module pru_cfg_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pru_pkg::PADDR_W-1:0]       paddr,
    input  logic [pru_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [pru_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    output pru_pkg::cfg_t                     cfg
);
    import pru_pkg::*;

    cfg_t                 cfg_reg;
    logic [REG_IDX_W-1:0] idx;
    logic                 wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[PADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.src_width  <= SRC_WIDTH_RST;
            cfg_reg.src_height <= SRC_HEIGHT_RST;
            cfg_reg.x_factor   <= X_FACTOR_RST;
            cfg_reg.y_factor   <= Y_FACTOR_RST;
            cfg_reg.x_gap      <= X_GAP_RST;
            cfg_reg.y_gap      <= Y_GAP_RST;
        end else if (wr_en) begin
            case (idx)
                REG_SRC_WIDTH:  cfg_reg.src_width  <= pwdata[SRC_DIM_W-1:0];
                REG_SRC_HEIGHT: cfg_reg.src_height <= pwdata[SRC_DIM_W-1:0];
                REG_X_FACTOR:   cfg_reg.x_factor   <= pwdata[FACTOR_W-1:0];
                REG_Y_FACTOR:   cfg_reg.y_factor   <= pwdata[FACTOR_W-1:0];
                REG_X_GAP:      cfg_reg.x_gap      <= pwdata[GAP_W-1:0];
                REG_Y_GAP:      cfg_reg.y_gap      <= pwdata[GAP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_SRC_WIDTH:  prdata = APB_DATA_W'(cfg_reg.src_width);
            REG_SRC_HEIGHT: prdata = APB_DATA_W'(cfg_reg.src_height);
            REG_X_FACTOR:   prdata = APB_DATA_W'(cfg_reg.x_factor);
            REG_Y_FACTOR:   prdata = APB_DATA_W'(cfg_reg.y_factor);
            REG_X_GAP:      prdata = APB_DATA_W'(cfg_reg.x_gap);
            REG_Y_GAP:      prdata = APB_DATA_W'(cfg_reg.y_gap);
            default:        prdata = '0;
        endcase
    end

endmodule

// ===== sv/pru_front.sv =====
// Front end: accepts source pixels, checks the configuration, steps the
// column/row counters and computes each pixel's block base address.
// Depends on pru_pkg.
module pru_front #(
    parameter int PIXEL_BITS      = pru_pkg::PIXEL_BITS_DEF,
    parameter int MAX_LINE_PIXELS = pru_pkg::MAX_LINE_PIXELS_DEF,
    parameter int MAX_FACTOR      = pru_pkg::MAX_FACTOR_DEF,
    localparam int W_W    = $clog2(MAX_LINE_PIXELS + 1),
    localparam int LINE_W = W_W + pru_pkg::FACTOR_W
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  pru_pkg::cfg_t                 cfg,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [PIXEL_BITS-1:0]         s_pixel,
    output logic                          q_push,
    input  logic                          q_full,
    output pru_pkg::cmd_ctl_t             q_ctl,
    output logic [PIXEL_BITS-1:0]         q_pixel,
    output logic [LINE_W-1:0]             q_line,
    output logic [pru_pkg::ADDR_W-1:0]    q_base
);
    import pru_pkg::*;

    localparam int COL_W  = $clog2(MAX_LINE_PIXELS);
    localparam int H_W    = $clog2(SRC_LINES_MAX + 1);
    localparam int RY_W   = ROW_W + FACTOR_W;
    localparam int CX_W   = COL_W + FACTOR_W;
    localparam int PROD_W = RY_W + LINE_W;

    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  row_reg;

    logic [W_W-1:0]    w_clamp;
    logic [H_W-1:0]    h_clamp;
    logic [W_W-1:0]    col_inc;
    logic [H_W-1:0]    row_inc;
    logic              last_col;
    logic              last_row;
    logic              cfg_bad;
    logic              accept;
    logic              b_free;
    logic              a_go;
    logic [PROD_W-1:0] prod;

    logic              a_valid_reg;
    logic [RY_W-1:0]   a_ry_reg;
    logic [LINE_W-1:0] a_line_reg;
    logic [CX_W-1:0]   a_cx_reg;
    cmd_ctl_t          a_ctl_reg;
    logic [PIXEL_BITS-1:0] a_pix_reg;

    logic              b_valid_reg;
    logic [ADDR_W-1:0] b_base_reg;
    logic [LINE_W-1:0] b_line_reg;
    cmd_ctl_t          b_ctl_reg;
    logic [PIXEL_BITS-1:0] b_pix_reg;

    always_comb begin
        if (cfg.src_width == '0) begin
            w_clamp = W_W'(1);
        end else if (int'(cfg.src_width) > MAX_LINE_PIXELS) begin
            w_clamp = W_W'(MAX_LINE_PIXELS);
        end else begin
            w_clamp = W_W'(cfg.src_width);
        end
        if (cfg.src_height == '0) begin
            h_clamp = H_W'(1);
        end else if (int'(cfg.src_height) > SRC_LINES_MAX) begin
            h_clamp = H_W'(SRC_LINES_MAX);
        end else begin
            h_clamp = H_W'(cfg.src_height);
        end
    end

    assign col_inc  = W_W'(col_reg) + W_W'(1);
    assign row_inc  = H_W'(row_reg) + H_W'(1);
    assign last_col = col_inc >= w_clamp;
    assign last_row = row_inc >= h_clamp;

    assign cfg_bad = (cfg.x_factor == FACTOR_W'(1) && cfg.y_factor == FACTOR_W'(1))
                  || cfg.x_factor == '0 || cfg.y_factor == '0
                  || int'(cfg.x_factor) > MAX_FACTOR || int'(cfg.y_factor) > MAX_FACTOR
                  || FACTOR_W'(cfg.x_gap) >= cfg.x_factor
                  || FACTOR_W'(cfg.y_gap) >= cfg.y_factor;

    assign b_free  = !b_valid_reg || !q_full;
    assign a_go    = a_valid_reg && b_free;
    assign s_ready = !a_valid_reg || b_free;
    assign accept  = s_valid && s_ready;
    assign prod    = PROD_W'(a_ry_reg) * PROD_W'(a_line_reg);

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= '0;
            row_reg     <= '0;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            if (accept && !cfg_bad) begin
                if (last_col) begin
                    col_reg <= '0;
                    row_reg <= last_row ? '0 : ROW_W'(row_inc);
                end else begin
                    col_reg <= COL_W'(col_inc);
                end
            end
            if (s_ready) begin
                a_valid_reg <= s_valid;
            end
            if (b_free) begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            a_ctl_reg.err <= cfg_bad;
            if (cfg_bad) begin
                a_ry_reg       <= '0;
                a_line_reg     <= '0;
                a_cx_reg       <= '0;
                a_pix_reg      <= '0;
                a_ctl_reg.fend <= 1'b0;
                a_ctl_reg.kx   <= FACTOR_W'(1);
                a_ctl_reg.ly   <= FACTOR_W'(1);
            end else begin
                a_ry_reg       <= RY_W'(row_reg) * RY_W'(cfg.y_factor);
                a_line_reg     <= LINE_W'(w_clamp) * LINE_W'(cfg.x_factor);
                a_cx_reg       <= CX_W'(col_reg) * CX_W'(cfg.x_factor);
                a_pix_reg      <= s_pixel;
                a_ctl_reg.fend <= last_col && last_row;
                a_ctl_reg.kx   <= cfg.x_factor - FACTOR_W'(cfg.x_gap);
                a_ctl_reg.ly   <= cfg.y_factor - FACTOR_W'(cfg.y_gap);
            end
        end
        if (a_go) begin
            b_base_reg <= ADDR_W'(prod) + ADDR_W'(a_cx_reg);
            b_line_reg <= a_line_reg;
            b_ctl_reg  <= a_ctl_reg;
            b_pix_reg  <= a_pix_reg;
        end
    end

    assign q_push  = b_valid_reg && !q_full;
    assign q_ctl   = b_ctl_reg;
    assign q_pixel = b_pix_reg;
    assign q_line  = b_line_reg;
    assign q_base  = b_base_reg;

endmodule

// ===== sv/pru_queue.sv =====
// Short register queue decoupling the front end from the back end.
// Depends on pru_pkg for the default depth and the assertion macros header.
`include "pixel_replication_upscaler_defines.svh"
module pru_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = pru_pkg::QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             nonempty
);
    import pru_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full     = count_reg == CNT_W'(DEPTH);
    assign nonempty = count_reg != '0;
    assign rdata    = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    `PRU_ASSERT_IMPL(a_no_overflow, aclk, aresetn, push, !full)
    `PRU_ASSERT_IMPL(a_no_underflow, aclk, aresetn, pop, nonempty)
    `PRU_ASSERT_NEXT(a_count_up, aclk, aresetn, push && !pop, count_reg == $past(count_reg) + CNT_W'(1))

endmodule

// ===== sv/pru_back.sv =====
// Back end: expands one queued pixel request into its block of writes,
// one write per cycle while the output accepts, through a registered output stage.
// Depends on pru_pkg and the assertion macros header.
`include "pixel_replication_upscaler_defines.svh"
module pru_back #(
    parameter int PIXEL_BITS      = pru_pkg::PIXEL_BITS_DEF,
    parameter int MAX_LINE_PIXELS = pru_pkg::MAX_LINE_PIXELS_DEF,
    localparam int LINE_W = $clog2(MAX_LINE_PIXELS + 1) + pru_pkg::FACTOR_W
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         q_valid,
    output logic                         q_pop,
    input  pru_pkg::cmd_ctl_t            q_ctl,
    input  logic [PIXEL_BITS-1:0]        q_pixel,
    input  logic [LINE_W-1:0]            q_line,
    input  logic [pru_pkg::ADDR_W-1:0]   q_base,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [pru_pkg::ADDR_W-1:0]   m_addr,
    output logic [PIXEL_BITS-1:0]        m_pixel,
    output logic                         m_err,
    output logic                         m_last,
    output logic                         m_fend
);
    import pru_pkg::*;

    logic                  act_valid_reg;
    cmd_ctl_t              act_ctl_reg;
    logic [PIXEL_BITS-1:0] act_pix_reg;
    logic [LINE_W-1:0]     act_line_reg;
    logic [ADDR_W-1:0]     cur_reg;
    logic [ADDR_W-1:0]     kbase_reg;
    logic [OFS_W-1:0]      k_reg;
    logic [OFS_W-1:0]      l_reg;

    logic                  m_valid_reg;
    logic [ADDR_W-1:0]     m_addr_reg;
    logic [PIXEL_BITS-1:0] m_pix_reg;
    logic                  m_err_reg;
    logic                  m_last_reg;
    logic                  m_fend_reg;

    logic out_free;
    logic step;
    logic l_last;
    logic k_last;
    logic blk_last;
    logic item_done;
    logic load;

    assign out_free  = !m_valid_reg || m_ready;
    assign step      = act_valid_reg && out_free;
    assign l_last    = (FACTOR_W'(l_reg) + FACTOR_W'(1)) == act_ctl_reg.ly;
    assign k_last    = (FACTOR_W'(k_reg) + FACTOR_W'(1)) == act_ctl_reg.kx;
    assign blk_last  = l_last && k_last;
    assign item_done = act_ctl_reg.err || blk_last;
    assign load      = q_valid && (!act_valid_reg || (step && item_done));
    assign q_pop     = load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (load) begin
                act_valid_reg <= 1'b1;
            end else if (step && item_done) begin
                act_valid_reg <= 1'b0;
            end
            if (step) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // offset walk: vertical offset inner, horizontal offset outer
    always_ff @(posedge aclk) begin
        if (load) begin
            act_ctl_reg  <= q_ctl;
            act_pix_reg  <= q_pixel;
            act_line_reg <= q_line;
            cur_reg      <= q_base;
            kbase_reg    <= q_base;
            k_reg        <= '0;
            l_reg        <= '0;
        end else if (step) begin
            if (l_last) begin
                k_reg     <= k_reg + OFS_W'(1);
                l_reg     <= '0;
                kbase_reg <= kbase_reg + ADDR_W'(1);
                cur_reg   <= kbase_reg + ADDR_W'(1);
            end else begin
                l_reg   <= l_reg + OFS_W'(1);
                cur_reg <= cur_reg + ADDR_W'(act_line_reg);
            end
        end
        if (step) begin
            m_addr_reg <= act_ctl_reg.err ? '0 : cur_reg;
            m_pix_reg  <= act_ctl_reg.err ? '0 : act_pix_reg;
            m_err_reg  <= act_ctl_reg.err;
            m_last_reg <= !act_ctl_reg.err && blk_last;
            m_fend_reg <= !act_ctl_reg.err && blk_last && act_ctl_reg.fend;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_addr  = m_addr_reg;
    assign m_pixel = m_pix_reg;
    assign m_err   = m_err_reg;
    assign m_last  = m_last_reg;
    assign m_fend  = m_fend_reg;

    `PRU_ASSERT_IMPL(a_err_clean, aclk, aresetn, m_valid_reg && m_err_reg, m_addr_reg == '0 && !m_last_reg && !m_fend_reg)
    `PRU_ASSERT_IMPL(a_fend_on_last, aclk, aresetn, m_valid_reg && m_fend_reg, m_last_reg)
    `PRU_ASSERT_IMPL(a_offsets_in_block, aclk, aresetn, act_valid_reg && !act_ctl_reg.err, (FACTOR_W'(l_reg) < act_ctl_reg.ly) && (FACTOR_W'(k_reg) < act_ctl_reg.kx))

endmodule

// ===== sv/pixel_replication_upscaler.sv =====
// Top level of the pixel replication upscaler: config registers, front end,
// request queue and write back end. Depends on pru_pkg and all pru_* modules.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------------------
//  s_      | in        | s_tvalid / s_tready   | s_tdata: pixel_in
//  m_      | out       | m_tvalid / m_tready   | m_tdata: dest_address, pixel_out;
//          |           |                       | m_tuser: config_error, frame_end; m_tlast
//  apb     | in        | psel / penable, write | six config registers at 4*index
//
// A source pixel yields (x_factor-x_gap)*(y_factor-y_gap) writes, one per cycle
// while the output accepts, from the back end's offset walk; a bad configuration
// yields one error write. Before its first write a request passes two front stages, the queue and the walk.
// Both sides stall independently through the four-entry request queue.
// Synchronous active-low reset; no memory clearing after reset.
module pixel_replication_upscaler #(
    parameter int PIXEL_BITS      = pru_pkg::PIXEL_BITS_DEF,
    parameter int MAX_LINE_PIXELS = pru_pkg::MAX_LINE_PIXELS_DEF,
    parameter int MAX_FACTOR      = pru_pkg::MAX_FACTOR_DEF,
    localparam int S_DATA_W = ((PIXEL_BITS + 7) / 8) * 8,
    localparam int M_DATA_W = ((pru_pkg::ADDR_W + PIXEL_BITS + 7) / 8) * 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [S_DATA_W-1:0]               s_tdata,   // [PIXEL_BITS-1:0] pixel_in
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [M_DATA_W-1:0]               m_tdata,   // dest_address, pixel_out
    output logic [1:0]                        m_tuser,   // config_error, frame_end
    output logic                              m_tlast,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pru_pkg::PADDR_W-1:0]       paddr,
    input  logic [pru_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [pru_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import pru_pkg::*;

    localparam int LINE_W = $clog2(MAX_LINE_PIXELS + 1) + FACTOR_W;
    localparam int CTL_W  = $bits(cmd_ctl_t);
    localparam int Q_W    = CTL_W + PIXEL_BITS + LINE_W + ADDR_W;

    cfg_t                  cfg;
    logic                  q_push;
    logic                  q_full;
    logic                  q_pop;
    logic                  q_nonempty;
    cmd_ctl_t              f_ctl;
    logic [PIXEL_BITS-1:0] f_pixel;
    logic [LINE_W-1:0]     f_line;
    logic [ADDR_W-1:0]     f_base;
    logic [Q_W-1:0]        q_wdata;
    logic [Q_W-1:0]        q_rdata;
    cmd_ctl_t              b_ctl;
    logic [PIXEL_BITS-1:0] b_pixel;
    logic [LINE_W-1:0]     b_line;
    logic [ADDR_W-1:0]     b_base;
    logic [ADDR_W-1:0]     m_addr;
    logic [PIXEL_BITS-1:0] m_pixel;
    logic                  m_err;
    logic                  m_fend;

    pru_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pru_front #(
        .PIXEL_BITS      (PIXEL_BITS),
        .MAX_LINE_PIXELS (MAX_LINE_PIXELS),
        .MAX_FACTOR      (MAX_FACTOR)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .s_pixel (s_tdata[PIXEL_BITS-1:0]),
        .q_push  (q_push),
        .q_full  (q_full),
        .q_ctl   (f_ctl),
        .q_pixel (f_pixel),
        .q_line  (f_line),
        .q_base  (f_base)
    );

    assign q_wdata = {f_ctl, f_pixel, f_line, f_base};
    assign {b_ctl, b_pixel, b_line, b_base} = q_rdata;

    pru_queue #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .wdata    (q_wdata),
        .full     (q_full),
        .pop      (q_pop),
        .rdata    (q_rdata),
        .nonempty (q_nonempty)
    );

    pru_back #(
        .PIXEL_BITS      (PIXEL_BITS),
        .MAX_LINE_PIXELS (MAX_LINE_PIXELS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_nonempty),
        .q_pop   (q_pop),
        .q_ctl   (b_ctl),
        .q_pixel (b_pixel),
        .q_line  (b_line),
        .q_base  (b_base),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_addr  (m_addr),
        .m_pixel (m_pixel),
        .m_err   (m_err),
        .m_last  (m_tlast),
        .m_fend  (m_fend)
    );

    assign m_tdata = M_DATA_W'({m_pixel, m_addr});
    assign m_tuser = {m_fend, m_err};

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for pixel_replication_upscaler: streams source pixels,
// programs the APB registers between phases and checks every destination write.
// Depends on pru_pkg and the upscaler RTL only.
module tb_top;
    import pru_pkg::*;

    localparam int PIX_W       = PIXEL_BITS_DEF;
    localparam int M_W         = ((ADDR_W + PIX_W + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct {
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  pix;
        logic              err;
        logic              last;
        logic              fend;
    } pixel_write_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;   // [7:0] pixel_in
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_W-1:0]        m_tdata;   // [29:0] dest_address, [37:30] pixel_out
    logic [1:0]            m_tuser;   // [0] config_error, [1] frame_end
    logic                  m_tlast;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_W-1:0]    paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    cfg_t              scale_cfg;
    logic [ROW_W-1:0]  src_col;
    logic [ROW_W-1:0]  src_row;
    pixel_write_t      expected_writes[$];
    int                error_count  = 0;
    int                items_sent   = 0;
    int                cycle_count  = 0;
    int                stall_left   = 0;
    bit                idle_en      = 1'b1;

    pixel_replication_upscaler u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // result side back-pressure
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idle_en && $urandom_range(0, 7) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 13);
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
            error_count++;
        end
    endtask

    always @(posedge aclk) begin
        pixel_write_t exp_wr;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_writes.size() == 0) begin
                $display("%0t: unexpected write, expected none actual addr %0h pix %0h",
                         $time, m_tdata[ADDR_W-1:0], m_tdata[ADDR_W +: PIX_W]);
                error_count++;
            end else begin
                exp_wr = expected_writes.pop_front();
                check_field("dest_address", 32'(exp_wr.addr), 32'(m_tdata[ADDR_W-1:0]));
                check_field("pixel_out", 32'(exp_wr.pix), 32'(m_tdata[ADDR_W +: PIX_W]));
                check_field("config_error", 32'(exp_wr.err), 32'(m_tuser[0]));
                check_field("frame_end", 32'(exp_wr.fend), 32'(m_tuser[1]));
                check_field("last_of_pixel", 32'(exp_wr.last), 32'(m_tlast));
            end
        end
    end

    // expected destination writes for one source pixel, then counter advance unless the configuration is bad
    function automatic void predict_pixel_writes(input logic [PIX_W-1:0] pix);
        int unsigned     w, h, xf, yf, xg, yg, kx, ly;
        longint unsigned dst_line, base;
        logic            last_col, last_row;
        pixel_write_t    wr;
        w  = scale_cfg.src_width;
        h  = scale_cfg.src_height;
        xf = scale_cfg.x_factor;
        yf = scale_cfg.y_factor;
        xg = scale_cfg.x_gap;
        yg = scale_cfg.y_gap;
        if (w < 1) w = 1;
        if (w > MAX_LINE_PIXELS_DEF) w = MAX_LINE_PIXELS_DEF;
        if (h < 1) h = 1;
        if (h > SRC_LINES_MAX) h = SRC_LINES_MAX;
        if ((xf == 1 && yf == 1) || xf == 0 || yf == 0 || xf > MAX_FACTOR_DEF ||
            yf > MAX_FACTOR_DEF || xg >= xf || yg >= yf) begin
            wr = '{addr: '0, pix: '0, err: 1'b1, last: 1'b0, fend: 1'b0};
            expected_writes.push_back(wr);
            return;
        end
        kx       = xf - xg;
        ly       = yf - yg;
        dst_line = longint'(w) * xf;
        base     = longint'(src_row) * yf * dst_line + longint'(src_col) * xf;
        last_col = (32'(src_col) + 1) >= w;
        last_row = (32'(src_row) + 1) >= h;
        for (int unsigned k = 0; k < kx; k++) begin
            for (int unsigned l = 0; l < ly; l++) begin
                wr.addr = ADDR_W'(base + l * dst_line + k);
                wr.pix  = pix;
                wr.err  = 1'b0;
                wr.last = (k + 1 == kx) && (l + 1 == ly);
                wr.fend = wr.last && last_col && last_row;
                expected_writes.push_back(wr);
            end
        end
        if (last_col) begin
            src_col = '0;
            src_row = last_row ? '0 : src_row + 1'b1;
        end else begin
            src_col = src_col + 1'b1;
        end
    endfunction

    task automatic send_pixel(input logic [PIX_W-1:0] pix);
        predict_pixel_writes(pix);
        items_sent++;
        @(negedge aclk);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = pix;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_idle;
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (expected_writes.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic apb_access(input logic [REG_IDX_W-1:0] idx, input logic wr,
                              input logic [APB_DATA_W-1:0] data,
                              output logic [APB_DATA_W-1:0] rdata);
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = PADDR_W'(idx) << 2;
        pwdata  = data;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    function automatic logic [APB_DATA_W-1:0] reg_value(input logic [REG_IDX_W-1:0] idx);
        case (idx)
            REG_SRC_WIDTH:  return APB_DATA_W'(scale_cfg.src_width);
            REG_SRC_HEIGHT: return APB_DATA_W'(scale_cfg.src_height);
            REG_X_FACTOR:   return APB_DATA_W'(scale_cfg.x_factor);
            REG_Y_FACTOR:   return APB_DATA_W'(scale_cfg.y_factor);
            REG_X_GAP:      return APB_DATA_W'(scale_cfg.x_gap);
            default:        return APB_DATA_W'(scale_cfg.y_gap);
        endcase
    endfunction

    task automatic read_check(input logic [REG_IDX_W-1:0] idx);
        logic [APB_DATA_W-1:0] rdata;
        apb_access(idx, 1'b0, '0, rdata);
        check_field("register readback", reg_value(idx), rdata);
    endtask

    // upper bits beyond the field are random junk half the time
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input int unsigned field);
        logic [APB_DATA_W-1:0] rdata;
        logic [APB_DATA_W-1:0] data;
        int                    fw;
        case (idx)
            REG_SRC_WIDTH, REG_SRC_HEIGHT: fw = SRC_DIM_W;
            REG_X_FACTOR, REG_Y_FACTOR:    fw = FACTOR_W;
            default:                       fw = GAP_W;
        endcase
        data = APB_DATA_W'(field);
        if ($urandom_range(0, 1) == 1) data = data | ($urandom() << fw);
        apb_access(idx, 1'b1, data, rdata);
        case (idx)
            REG_SRC_WIDTH:  scale_cfg.src_width  = data[SRC_DIM_W-1:0];
            REG_SRC_HEIGHT: scale_cfg.src_height = data[SRC_DIM_W-1:0];
            REG_X_FACTOR:   scale_cfg.x_factor   = data[FACTOR_W-1:0];
            REG_Y_FACTOR:   scale_cfg.y_factor   = data[FACTOR_W-1:0];
            REG_X_GAP:      scale_cfg.x_gap      = data[GAP_W-1:0];
            default:        scale_cfg.y_gap      = data[GAP_W-1:0];
        endcase
        read_check(idx);
    endtask

    task automatic set_scaling(input int unsigned w, input int unsigned h,
                               input int unsigned xf, input int unsigned yf,
                               input int unsigned xg, input int unsigned yg);
        wait_idle();
        write_reg(REG_SRC_WIDTH, w);
        write_reg(REG_SRC_HEIGHT, h);
        write_reg(REG_X_FACTOR, xf);
        write_reg(REG_Y_FACTOR, yf);
        write_reg(REG_X_GAP, xg);
        write_reg(REG_Y_GAP, yg);
    endtask

    task automatic test_register_defaults;
        read_check(REG_SRC_WIDTH);
        read_check(REG_SRC_HEIGHT);
        read_check(REG_X_FACTOR);
        read_check(REG_Y_FACTOR);
        read_check(REG_X_GAP);
        read_check(REG_Y_GAP);
    endtask

    task automatic test_pixel_extremes;
        send_pixel(8'h00);
        send_pixel(8'hFF);
        send_pixel(8'h5A);
        send_pixel(8'hA5);
    endtask

    task automatic test_factor_extremes;
        set_scaling(5, 3, 8, 8, 0, 0);
        send_pixel(8'h81);
        set_scaling(5, 3, 8, 8, 7, 7);
        send_pixel(8'h7E);
        set_scaling(7, 3, 1, 8, 0, 3);
        send_pixel(8'h33);
        set_scaling(7, 3, 8, 1, 5, 0);
        send_pixel(8'hCC);
    endtask

    task automatic test_bad_config;
        set_scaling(4, 4, 1, 1, 0, 0);
        send_pixel(8'h11);
        set_scaling(4, 4, 0, 3, 0, 0);
        send_pixel(8'h22);
        set_scaling(4, 4, 2, 15, 0, 0);
        send_pixel(8'h44);
        set_scaling(4, 4, 3, 2, 3, 0);
        send_pixel(8'h88);
        set_scaling(4, 4, 2, 4, 1, 7);
        send_pixel(8'hF0);
    endtask

    task automatic test_size_clamp;
        set_scaling(0, 0, 2, 3, 1, 0);
        send_pixel(8'h0F);
        send_pixel(8'hE1);
        set_scaling(8191, 8191, 3, 2, 0, 1);
        send_pixel(8'h96);
    endtask

    // counters left beyond a smaller width or height wrap on the next pixel
    task automatic test_counter_wrap;
        set_scaling(4096, 4096, 2, 2, 0, 0);
        repeat (3) send_pixel($urandom_range(0, 255));
        set_scaling(2, 4096, 2, 2, 0, 0);
        send_pixel($urandom_range(0, 255));
        set_scaling(1, 4096, 2, 2, 0, 0);
        repeat (2) send_pixel($urandom_range(0, 255));
        set_scaling(1, 1, 2, 2, 0, 0);
        send_pixel($urandom_range(0, 255));
        set_scaling(2, 2, 2, 3, 1, 1);
        repeat (3) send_pixel($urandom_range(0, 255));
    endtask

    task automatic random_setup;
        int unsigned w, h, xf, yf, xg, yg;
        w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 8);
        h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 6);
        if ($urandom_range(0, 7) == 0) begin
            xf = $urandom_range(0, 15);
            yf = $urandom_range(0, 15);
            xg = $urandom_range(0, 7);
            yg = $urandom_range(0, 7);
        end else begin
            do begin
                xf = $urandom_range(1, 8);
                yf = $urandom_range(1, 8);
            end while (xf == 1 && yf == 1);
            xg = $urandom_range(0, xf - 1);
            yg = $urandom_range(0, yf - 1);
        end
        set_scaling(w, h, xf, yf, xg, yg);
    endtask

    task automatic test_random_frames;
        while (items_sent < 85) begin
            random_setup();
            repeat ($urandom_range(6, 14)) send_pixel($urandom_range(0, 255));
        end
        idle_en = 1'b0;
        random_setup();
        repeat (20) send_pixel($urandom_range(0, 255));
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        scale_cfg = '{src_width: SRC_WIDTH_RST, src_height: SRC_HEIGHT_RST,
                      x_factor: X_FACTOR_RST, y_factor: Y_FACTOR_RST,
                      x_gap: X_GAP_RST, y_gap: Y_GAP_RST};
        src_col   = '0;
        src_row   = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_register_defaults();
        test_pixel_extremes();
        test_factor_extremes();
        test_bad_config();
        test_size_clamp();
        test_counter_wrap();
        test_random_frames();

        wait_idle();
        repeat (20) @(posedge aclk);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
